// ===== rtl/acst_pkg.sv =====
// Shared constants and helpers for the alignment column scorer.
package acst_pkg;

  localparam int unsigned MAX_COLUMNS = 65536;
  // Column counters and the position saturate against this limit
  localparam int unsigned COL_LIMIT = (MAX_COLUMNS < 65536) ? MAX_COLUMNS : 65536;

  localparam int CNT_W   = 17;
  localparam int POS_W   = 16;
  localparam int SCORE_W = 32;
  localparam int BEST_W  = 31;
  localparam int CHAR_W  = 8;
  localparam int REG_W   = 8;
  localparam int DELTA_W = 10;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 152;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_MATCH      = 2'd0;
  localparam logic [1:0] REG_MISMATCH   = 2'd1;
  localparam logic [1:0] REG_GAP_OPEN   = 2'd2;
  localparam logic [1:0] REG_GAP_EXTEND = 2'd3;

  localparam logic [REG_W-1:0] RST_MATCH      = 8'sd5;
  localparam logic [REG_W-1:0] RST_MISMATCH   = 8'hFC;
  localparam logic [REG_W-1:0] RST_GAP_OPEN   = 8'hD8;
  localparam logic [REG_W-1:0] RST_GAP_EXTEND = 8'hFF;

  localparam logic [CHAR_W-1:0] CHAR_GAP = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_N   = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_LA  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ  = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COL_LIMIT);

  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_OFS : c;
  endfunction

  function automatic logic [CNT_W-1:0] bump_cnt(input logic [CNT_W-1:0] v);
    return (v < CNT_LIMIT) ? v + CNT_W'(1) : v;
  endfunction

endpackage

// ===== rtl/alignment_column_score_trim.sv =====
// Alignment column scorer: affine running score, best prefix and column counters.
// A column accepted into the input register goes through the scoring logic into
// the result register.
// Throughput: one column per cycle unless out_tready stalls; the score/best/counter
// update is a single 33-bit add, saturate and compare between the two registers.
// Reset: synchronous active-low; run state clears to zero, weight registers
// return to 5, -4, -40, -1. No clearing pass.
module alignment_column_score_trim (
  input  logic                          clk,
  input  logic                          rst_n,
  // APB-style configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [acst_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [acst_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [acst_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready,
  // Column input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [acst_pkg::IN_DATA_W-1:0] in_tdata,  // query_char[7:0], target_char[15:8]
  input  logic                          in_tuser,  // first_column
  input  logic                          in_tlast,  // last_column
  // Result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // running_score[31:0], best_score[62:32], best_position[78:63], best_found[79],
  // match_count[96:80], mismatch_count[113:97], gap_column_count[130:114],
  // gap_run_count[147:131], zero pad[151:148]
  output logic [acst_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast  // final_flag
);
  import acst_pkg::*;

  // Configuration registers
  logic [REG_W-1:0] match_r, mismatch_r, open_pen_r, gap_ext_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= RST_MATCH;
      mismatch_r <= RST_MISMATCH;
      open_pen_r <= RST_GAP_OPEN;
      gap_ext_r  <= RST_GAP_EXTEND;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MATCH:      match_r    <= cfg_pwdata[REG_W-1:0];
        REG_MISMATCH:   mismatch_r <= cfg_pwdata[REG_W-1:0];
        REG_GAP_OPEN:   open_pen_r <= cfg_pwdata[REG_W-1:0];
        REG_GAP_EXTEND: gap_ext_r  <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MATCH:      cfg_prdata = {{(CFG_DATA_W-REG_W){match_r[REG_W-1]}}, match_r};
      REG_MISMATCH:   cfg_prdata = {{(CFG_DATA_W-REG_W){mismatch_r[REG_W-1]}}, mismatch_r};
      REG_GAP_OPEN:   cfg_prdata = {{(CFG_DATA_W-REG_W){open_pen_r[REG_W-1]}}, open_pen_r};
      REG_GAP_EXTEND: cfg_prdata = {{(CFG_DATA_W-REG_W){gap_ext_r[REG_W-1]}}, gap_ext_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Input register
  logic              s1_valid_r;
  logic              s1_first_r, s1_last_r;
  logic [CHAR_W-1:0] s1_q_r, s1_t_r;
  logic              s1_move;
  logic              out_valid_r;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
      s1_q_r     <= in_tdata[7:0];
      s1_t_r     <= in_tdata[15:8];
    end
  end

  // Run state
  logic signed [SCORE_W-1:0] score_r;
  logic signed [SCORE_W-1:0] best_r;
  logic [POS_W-1:0]          best_idx_r, col_idx_r;
  logic                      best_seen_r, prev_qg_r, prev_tg_r;
  logic [CNT_W-1:0]          match_cnt_r, mism_cnt_r, gcol_cnt_r, grun_cnt_r;

  // State seen by this column (cleared when it opens a new alignment)
  logic signed [SCORE_W-1:0] base_score, base_best;
  logic [POS_W-1:0]          base_best_idx, base_col_idx;
  logic                      base_seen, base_pqg, base_ptg;
  logic [CNT_W-1:0]          base_match, base_mism, base_gcol, base_grun;

  always_comb begin
    if (s1_first_r) begin
      base_score    = '0;
      base_best     = '0;
      base_best_idx = '0;
      base_col_idx  = '0;
      base_seen     = 1'b0;
      base_pqg      = 1'b0;
      base_ptg      = 1'b0;
      base_match    = '0;
      base_mism     = '0;
      base_gcol     = '0;
      base_grun     = '0;
    end else begin
      base_score    = score_r;
      base_best     = best_r;
      base_best_idx = best_idx_r;
      base_col_idx  = col_idx_r;
      base_seen     = best_seen_r;
      base_pqg      = prev_qg_r;
      base_ptg      = prev_tg_r;
      base_match    = match_cnt_r;
      base_mism     = mism_cnt_r;
      base_gcol     = gcol_cnt_r;
      base_grun     = grun_cnt_r;
    end
  end

  // Column classification and score delta
  logic              qg, tg, is_match, is_mism, is_gap, run_opens;
  logic [CHAR_W-1:0] qu, tu;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] score_nxt, best_nxt;
  logic [POS_W-1:0]          best_idx_nxt, col_idx_nxt;
  logic                      seen_nxt, new_best;
  logic [CNT_W-1:0]          match_nxt, mism_nxt, gcol_nxt, grun_nxt;

  always_comb begin
    qg        = (s1_q_r == CHAR_GAP);
    tg        = (s1_t_r == CHAR_GAP);
    qu        = upcase(s1_q_r);
    tu        = upcase(s1_t_r);
    is_gap    = qg || tg;
    is_match  = !is_gap && (qu != CHAR_N) && (tu != CHAR_N) && (qu == tu);
    is_mism   = !is_gap && !is_match;
    run_opens = (qg && !base_pqg) || (tg && !base_ptg);

    if (is_match) begin
      delta = DELTA_W'(signed'(match_r));
    end else if (is_mism) begin
      delta = DELTA_W'(signed'(mismatch_r));
    end else begin
      delta = DELTA_W'(signed'(gap_ext_r)) +
              (run_opens ? DELTA_W'(signed'(open_pen_r)) : DELTA_W'(0));
    end

    sum = {base_score[SCORE_W-1], base_score} + (SCORE_W+1)'(delta);
    // Saturate when the 33-bit sum leaves the 32-bit range
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      score_nxt = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      score_nxt = sum[SCORE_W-1:0];
    end

    new_best     = (score_nxt >= base_best);
    best_nxt     = new_best ? score_nxt : base_best;
    best_idx_nxt = new_best ? base_col_idx : base_best_idx;
    seen_nxt     = new_best || base_seen;

    col_idx_nxt = (({1'b0, base_col_idx} + CNT_W'(1)) < CNT_LIMIT) ?
                  base_col_idx + POS_W'(1) : base_col_idx;

    match_nxt = is_match ? bump_cnt(base_match) : base_match;
    mism_nxt  = is_mism ? bump_cnt(base_mism) : base_mism;
    gcol_nxt  = is_gap ? bump_cnt(base_gcol) : base_gcol;
    grun_nxt  = (is_gap && run_opens) ? bump_cnt(base_grun) : base_grun;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r     <= '0;
      best_r      <= '0;
      best_idx_r  <= '0;
      col_idx_r   <= '0;
      best_seen_r <= 1'b0;
      prev_qg_r   <= 1'b0;
      prev_tg_r   <= 1'b0;
      match_cnt_r <= '0;
      mism_cnt_r  <= '0;
      gcol_cnt_r  <= '0;
      grun_cnt_r  <= '0;
    end else if (s1_move) begin
      score_r     <= score_nxt;
      best_r      <= best_nxt;
      best_idx_r  <= best_idx_nxt;
      col_idx_r   <= col_idx_nxt;
      best_seen_r <= seen_nxt;
      prev_qg_r   <= qg;
      prev_tg_r   <= tg;
      match_cnt_r <= match_nxt;
      mism_cnt_r  <= mism_nxt;
      gcol_cnt_r  <= gcol_nxt;
      grun_cnt_r  <= grun_nxt;
    end
  end

  // Result register
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= {4'b0, grun_nxt, gcol_nxt, mism_nxt, match_nxt, seen_nxt,
                     best_idx_nxt, best_nxt[BEST_W-1:0], score_nxt};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== dv/alignment_column_score_trim_test.sv =====
// Self-checking testbench for the alignment column scorer.
`timescale 1ns / 100ps

module alignment_column_score_trim_test;
  import acst_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  PHASES      = 6;
  localparam int  PHASE_ITEMS = 325;
  localparam longint SCORE_MAX = 64'sd2147483647;
  localparam longint SCORE_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [SCORE_W-1:0] running_score;
    logic [BEST_W-1:0]         best_score;
    logic [POS_W-1:0]          best_position;
    logic                      best_found;
    logic [CNT_W-1:0]          match_count;
    logic [CNT_W-1:0]          mismatch_count;
    logic [CNT_W-1:0]          gap_column_count;
    logic [CNT_W-1:0]          gap_run_count;
    logic                      final_flag;
  } column_result_t;

  class column_scoreboard;
    logic signed [REG_W-1:0]   match_w, mismatch_w, open_pen_w, gap_extend_w;
    logic signed [SCORE_W-1:0] score, best;
    int unsigned               best_pos, col_pos;
    bit                        best_hit, q_gap_prev, t_gap_prev;
    int unsigned               n_match, n_mismatch, n_gap_col, n_gap_run;
    column_result_t            expected_q[$];
    int                        errors;
    int                        results_seen;

    function new();
      match_w      = RST_MATCH;
      mismatch_w   = RST_MISMATCH;
      open_pen_w   = RST_GAP_OPEN;
      gap_extend_w = RST_GAP_EXTEND;
      errors       = 0;
      results_seen = 0;
      clear_run();
    endfunction

    function void clear_run();
      score      = '0;
      best       = '0;
      best_pos   = 0;
      best_hit   = 1'b0;
      col_pos    = 0;
      q_gap_prev = 1'b0;
      t_gap_prev = 1'b0;
      n_match    = 0;
      n_mismatch = 0;
      n_gap_col  = 0;
      n_gap_run  = 0;
    endfunction

    function void set_weight(logic [1:0] index, logic [REG_W-1:0] value);
      case (index)
        REG_MATCH:      match_w      = value;
        REG_MISMATCH:   mismatch_w   = value;
        REG_GAP_OPEN:   open_pen_w   = value;
        REG_GAP_EXTEND: gap_extend_w = value;
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned v);
      return (v < COL_LIMIT) ? v + 1 : v;
    endfunction

    function logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
      return (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_OFS : c;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Accepted column request: advance the model state, queue the result
    function void note_column(logic first, logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] t,
                              logic last);
      column_result_t    r;
      logic              q_gap, t_gap;
      logic [CHAR_W-1:0] qu, tu;
      longint            delta, sum;
      q_gap = (q == CHAR_GAP);
      t_gap = (t == CHAR_GAP);
      qu    = fold_case(q);
      tu    = fold_case(t);
      delta = 0;
      if (first) clear_run();
      if (!q_gap && !t_gap && qu != CHAR_N && tu != CHAR_N && qu == tu) begin
        delta   = match_w;
        n_match = bump(n_match);
      end else if (!q_gap && !t_gap) begin
        delta      = mismatch_w;
        n_mismatch = bump(n_mismatch);
      end else begin
        // a column gapped on both sides still opens at most one run
        if ((q_gap && !q_gap_prev) || (t_gap && !t_gap_prev)) begin
          delta     = delta + open_pen_w;
          n_gap_run = bump(n_gap_run);
        end
        delta     = delta + gap_extend_w;
        n_gap_col = bump(n_gap_col);
      end
      q_gap_prev = q_gap;
      t_gap_prev = t_gap;

      sum = longint'(score) + delta;
      if (sum > SCORE_MAX) sum = SCORE_MAX;
      if (sum < SCORE_MIN) sum = SCORE_MIN;
      score = sum[SCORE_W-1:0];

      if (score >= best) begin
        best     = score;
        best_pos = col_pos;
        best_hit = 1'b1;
      end
      if (col_pos + 1 < COL_LIMIT) col_pos++;

      r.running_score    = score;
      r.best_score       = best[BEST_W-1:0];
      r.best_position    = best_pos[POS_W-1:0];
      r.best_found       = best_hit;
      r.match_count      = n_match[CNT_W-1:0];
      r.mismatch_count   = n_mismatch[CNT_W-1:0];
      r.gap_column_count = n_gap_col[CNT_W-1:0];
      r.gap_run_count    = n_gap_run[CNT_W-1:0];
      r.final_flag       = last;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d field %s expected %0h got %0h",
                   results_seen, field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      column_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d arrived with no column pending", results_seen);
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        check_field("running_score",    want.running_score,    data[31:0]);
        check_field("best_score",       want.best_score,       data[62:32]);
        check_field("best_position",    want.best_position,    data[78:63]);
        check_field("best_found",       want.best_found,       data[79]);
        check_field("match_count",      want.match_count,      data[96:80]);
        check_field("mismatch_count",   want.mismatch_count,   data[113:97]);
        check_field("gap_column_count", want.gap_column_count, data[130:114]);
        check_field("gap_run_count",    want.gap_run_count,    data[147:131]);
        check_field("final_flag",       want.final_flag,       last);
      end
      results_seen++;
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata    = '0;  // query_char[7:0], target_char[15:8]
  logic                    in_tuser    = 1'b0; // first_column
  logic                    in_tlast    = 1'b0; // last_column
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  // running_score, best_score, best_position, best_found, match_count,
  // mismatch_count, gap_column_count, gap_run_count, zero pad
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tlast;      // final_flag

  column_scoreboard sb = new();
  int               send_idle_pct = 20;
  int               recv_idle_pct = 51;
  int               cycle_count   = 0;
  int               gap_side      = 0;

  logic [CHAR_W-1:0] bases [5] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E};

  alignment_column_score_trim dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check at the handshake edge, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_column(logic first, logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] t,
                             logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, q};
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_column(first, q, t, last);
  endtask

  task automatic write_weight(logic [1:0] index, logic [REG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= {24'($urandom_range(0, 16777215)), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_weight(index, value);
    @(posedge clk);
  endtask

  task automatic write_weights(logic [REG_W-1:0] m, logic [REG_W-1:0] mm,
                               logic [REG_W-1:0] go, logic [REG_W-1:0] ge);
    write_weight(REG_MATCH, m);
    write_weight(REG_MISMATCH, mm);
    write_weight(REG_GAP_OPEN, go);
    write_weight(REG_GAP_EXTEND, ge);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] random_base();
    logic [CHAR_W-1:0] c;
    c = bases[$urandom_range(0, 4)];
    return $urandom_range(0, 1) ? (c | CASE_OFS) : c;
  endfunction

  // One column of a plausible alignment, sometimes raw noise
  task automatic random_column(logic first, logic last);
    int                kind;
    logic [CHAR_W-1:0] q, t;
    kind = $urandom_range(0, 99);
    q    = random_base();
    t    = random_base();
    if (kind < 8) begin
      q = CHAR_W'($urandom_range(0, 255));
      t = CHAR_W'($urandom_range(0, 255));
    end else if (kind < 28) begin
      // gap runs tend to continue on the same side
      if ($urandom_range(0, 99) < 40) gap_side = $urandom_range(0, 2);
      if (gap_side != 1) q = CHAR_GAP;
      if (gap_side != 0) t = CHAR_GAP;
    end else if (kind < 75) begin
      t = $urandom_range(0, 1) ? (q | CASE_OFS) : (q & ~CASE_OFS);
    end
    send_column(first, q, t, last);
  endtask

  task automatic random_alignment(output int columns);
    int len;
    bit mark_first, mark_last;
    len        = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                             : $urandom_range(1, 40);
    mark_first = ($urandom_range(0, 19) != 0);
    mark_last  = ($urandom_range(0, 19) != 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 49) == 0)
        random_column(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        random_column(mark_first && i == 0, mark_last && i == len - 1);
    end
    columns = len;
  endtask

  initial begin
    int sent, cols;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed columns under the reset weights
    send_column(1'b1, 8'h41, 8'h41, 1'b0);         // match
    send_column(1'b0, 8'h61, 8'h41, 1'b0);         // match, case folded
    send_column(1'b0, CHAR_N, CHAR_N, 1'b0);       // N never matches
    send_column(1'b0, 8'h6E, 8'h41, 1'b0);
    send_column(1'b0, CHAR_GAP, 8'h41, 1'b0);      // query gap opens
    send_column(1'b0, CHAR_GAP, 8'h43, 1'b0);      // extends
    send_column(1'b0, 8'h47, CHAR_GAP, 1'b0);      // target side opens
    send_column(1'b0, CHAR_GAP, CHAR_GAP, 1'b0);   // both sides, query starts new
    send_column(1'b0, CHAR_GAP, CHAR_GAP, 1'b0);   // both continue, no open
    send_column(1'b0, 8'hFF, 8'hFF, 1'b0);         // high bytes compare as is
    send_column(1'b0, 8'h00, 8'h80, 1'b0);
    send_column(1'b0, 8'h7A, 8'h5A, 1'b1);
    send_column(1'b0, 8'h54, 8'h74, 1'b0);         // carries on past last
    send_column(1'b1, CHAR_GAP, CHAR_GAP, 1'b0);   // gap at the very first column
    send_column(1'b0, 8'h40, 8'h40, 1'b0);
    send_column(1'b0, 8'h7B, 8'h5B, 1'b1);         // braces are not folded
    send_column(1'b1, 8'hAA, 8'h55, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0:       begin send_idle_pct = 20; recv_idle_pct = 51; end
        1:       begin send_idle_pct = 51; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (phase > 0) begin
        drain();
        case (phase)
          1:       write_weights(8'h7F, 8'h80, 8'h80, 8'h80);
          2:       write_weights(8'h80, 8'h7F, 8'h7F, 8'h7F);
          3:       write_weights(8'h00, 8'h00, 8'h00, 8'h00);
          default: write_weights(REG_W'($urandom_range(0, 255)),
                                 REG_W'($urandom_range(0, 255)),
                                 REG_W'($urandom_range(0, 255)),
                                 REG_W'($urandom_range(0, 255)));
        endcase
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_alignment(cols);
        sent += cols;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
